FILE: hdl/pau_pkg.sv
// ---------------------------------------------------------------------------
// pau_pkg : shared types and constants for the pixel arithmetic unit
// Holds the opcode set, the per-stage control word, the angle format and the
// arctangent table used by the CORDIC cells.
// ---------------------------------------------------------------------------
package pau_pkg;

  // Default fraction width of a pixel (1.0 = 2**FRAC_BITS)
  localparam int DEF_FRAC_BITS = 8;

  // Angle accumulator in Q30 radians
  localparam int ANG_BITS     = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int Z_W          = 32;

  // Headroom on x/y for CORDIC gain and the vector length
  localparam int XY_GUARD = 3;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_MIN   = 4'd4,
    OP_MAX   = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_XOR   = 4'd8,
    OP_NOT   = 4'd9,
    OP_ATAN2 = 4'd10
  } op_t;

  // Control word handed along the cell chain
  typedef struct packed {
    logic valid;   // stage holds a beat
    logic fixed;   // result already settled at entry
    logic is_div;  // quotient path chosen, else angle path
  } ctl_t;

  // atan(2**-idx) in Q30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = 32'sd843314856;
      1:       v = 32'sd497837829;
      2:       v = 32'sd263043836;
      3:       v = 32'sd133525158;
      4:       v = 32'sd67021686;
      5:       v = 32'sd33543515;
      6:       v = 32'sd16775850;
      7:       v = 32'sd8388437;
      8:       v = 32'sd4194282;
      9:       v = 32'sd2097149;
      10:      v = 32'sd1048575;
      11:      v = 32'sd524287;
      default: v = (32'sd1 <<< (ANG_BITS - idx)) - 32'sd1;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/pixel_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// pixel_arithmetic_unit : two-image pixel ALU
// Pipeline: entry stage, 30 cells and output register from input beat to
// result. Throughput: one beat per cycle; the whole chain advances together
// and stalls only while a result waits at the output. Reset clears all valid
// bits and sets the operation to ADD; no clearing pass is needed.
// ---------------------------------------------------------------------------
module pixel_arithmetic_unit #(
  parameter int FRAC_BITS = pau_pkg::DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   pixel_a,
  input  logic [FRAC_BITS:0]   pixel_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   pixel_out
);
  import pau_pkg::*;

  localparam int PIX_W = FRAC_BITS + 1;
  localparam int REM_W = FRAC_BITS + 2;
  localparam int XY_W  = FRAC_BITS + 1 + ANG_BITS + XY_GUARD;
  localparam int N     = CORDIC_STEPS;
  localparam logic [PIX_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  op_t                    operation;
  logic                   adv;
  ctl_t                   ctl_s [0:N];
  logic signed [XY_W-1:0] x_s   [0:N];
  logic signed [XY_W-1:0] y_s   [0:N];
  logic signed [Z_W-1:0]  z_s   [0:N];
  logic [REM_W-1:0]       rem_s [0:N];
  logic [PIX_W-1:0]       q_s   [0:N];
  logic [PIX_W-1:0]       b_s   [0:N];
  logic [PIX_W-1:0]       res_s [0:N];

  // Operation register
  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= OP_ADD;
    end else if (cfg_write) begin
      operation <= op_t'(cfg_data);
    end
  end

  // Advance the chain unless a result is held at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  pau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .operation (operation),
    .pixel_a   (pixel_a),
    .pixel_b   (pixel_b),
    .ctl_out   (ctl_s[0]),
    .x_out     (x_s[0]),
    .y_out     (y_s[0]),
    .z_out     (z_s[0]),
    .rem_out   (rem_s[0]),
    .q_out     (q_s[0]),
    .b_out     (b_s[0]),
    .res_out   (res_s[0])
  );

  // Row of cells, one rotation each
  generate
    for (genvar i = 0; i < N; i++) begin : g_cell
      pau_cell #(.FRAC_BITS(FRAC_BITS), .IDX(i)) u_cell (
        .clk     (clk),
        .rst     (rst),
        .adv     (adv),
        .ctl_in  (ctl_s[i]),
        .x_in    (x_s[i]),
        .y_in    (y_s[i]),
        .z_in    (z_s[i]),
        .rem_in  (rem_s[i]),
        .q_in    (q_s[i]),
        .b_in    (b_s[i]),
        .res_in  (res_s[i]),
        .ctl_out (ctl_s[i+1]),
        .x_out   (x_s[i+1]),
        .y_out   (y_s[i+1]),
        .z_out   (z_s[i+1]),
        .rem_out (rem_s[i+1]),
        .q_out   (q_s[i+1]),
        .b_out   (b_s[i+1]),
        .res_out (res_s[i+1])
      );
    end
  endgenerate

  pau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl_in    (ctl_s[N]),
    .z_in      (z_s[N]),
    .q_in      (q_s[N]),
    .res_in    (res_s[N]),
    .out_valid (out_valid),
    .pixel_out (pixel_out)
  );

  // Results never exceed 1.0
  a_out_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_out <= ONE))
    else $error("pixel_arithmetic_unit: result above 1.0");

  // An accepted beat enters the entry stage
  a_beat_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ctl_s[0].valid)
    else $error("pixel_arithmetic_unit: accepted beat lost at entry");

  // A stall is only ever caused by a held result
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> out_valid)
    else $error("pixel_arithmetic_unit: held result vanished during stall");

endmodule

FILE: hdl/pau_front.sv
// ---------------------------------------------------------------------------
// pau_front : entry stage of the pixel arithmetic unit
// Works out every single-step operation, the special cases of DIV and ATAN2,
// and loads the starting vector and remainder for the cell chain.
// ---------------------------------------------------------------------------
module pau_front #(
  parameter int FRAC_BITS = pau_pkg::DEF_FRAC_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            adv,
  input  logic                                            in_valid,
  input  pau_pkg::op_t                                    operation,
  input  logic [FRAC_BITS:0]                              pixel_a,
  input  logic [FRAC_BITS:0]                              pixel_b,
  output pau_pkg::ctl_t                                   ctl_out,
  output logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] x_out,
  output logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] y_out,
  output logic signed [pau_pkg::Z_W-1:0]                  z_out,
  output logic [FRAC_BITS+1:0]                            rem_out,
  output logic [FRAC_BITS:0]                              q_out,
  output logic [FRAC_BITS:0]                              b_out,
  output logic [FRAC_BITS:0]                              res_out
);
  import pau_pkg::*;

  localparam int PIX_W = FRAC_BITS + 1;
  localparam int RAW_W = FRAC_BITS + 2;
  localparam int XY_W  = FRAC_BITS + 1 + ANG_BITS + XY_GUARD;
  localparam logic [PIX_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic               ta, tb;
  logic [RAW_W-1:0]   sum_ab;
  logic [2*PIX_W-1:0] prod_ab;
  logic [RAW_W-1:0]   raw;
  logic [PIX_W-1:0]   res_next;
  logic               fixed_next;
  logic               is_div_next;

  assign ta      = (pixel_a == ONE);
  assign tb      = (pixel_b == ONE);
  assign sum_ab  = {1'b0, pixel_a} + {1'b0, pixel_b};
  assign prod_ab = {{PIX_W{1'b0}}, pixel_a} * {{PIX_W{1'b0}}, pixel_b};

  // Decode the operation into a raw result and the path flags
  always_comb begin
    raw         = '0;
    fixed_next  = 1'b1;
    is_div_next = 1'b0;
    unique case (operation)
      OP_ADD: raw = sum_ab;
      OP_SUB: raw = (pixel_a > pixel_b) ? {1'b0, pixel_a - pixel_b} : '0;
      OP_MUL: raw = prod_ab[2*PIX_W-1:FRAC_BITS];
      OP_DIV: begin
        is_div_next = 1'b1;
        if (pixel_b == '0) begin
          raw = '0;
        end else if ({1'b0, pixel_a} >= {pixel_b, 1'b0}) begin
          raw = {1'b0, ONE};
        end else begin
          fixed_next = 1'b0;
        end
      end
      OP_MIN: raw = {1'b0, (pixel_a < pixel_b) ? pixel_a : pixel_b};
      OP_MAX: raw = {1'b0, (pixel_a > pixel_b) ? pixel_a : pixel_b};
      OP_AND: raw = (ta && tb) ? {1'b0, ONE} : '0;
      OP_OR:  raw = (ta || tb) ? {1'b0, ONE} : '0;
      OP_XOR: raw = (ta != tb) ? {1'b0, ONE} : '0;
      OP_NOT: raw = ta ? '0 : {1'b0, ONE};
      OP_ATAN2: begin
        if (pixel_a == '0) begin
          raw = '0;
        end else if (pixel_b == '0) begin
          raw = {1'b0, ONE};
        end else begin
          fixed_next = 1'b0;
        end
      end
      default: raw = '0;
    endcase
  end

  // Cap at 1.0
  assign res_next = (raw > {1'b0, ONE}) ? ONE : raw[PIX_W-1:0];

  // Hold control; clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out.valid  <= in_valid;
      ctl_out.fixed  <= fixed_next;
      ctl_out.is_div <= is_div_next;
    end
  end

  // Load the starting vector, remainder and settled result
  always_ff @(posedge clk) begin
    if (adv) begin
      x_out   <= XY_W'({pixel_b, {ANG_BITS{1'b0}}});
      y_out   <= XY_W'({pixel_a, {ANG_BITS{1'b0}}});
      z_out   <= '0;
      rem_out <= {1'b0, pixel_a};
      q_out   <= '0;
      b_out   <= pixel_b;
      res_out <= res_next;
    end
  end

endmodule

FILE: hdl/pau_cell.sv
// ---------------------------------------------------------------------------
// pau_cell : one cell of the arithmetic chain
// Performs one CORDIC vectoring rotation and, in the leading cells, one
// restoring division step, then hands the beat to the next cell.
// ---------------------------------------------------------------------------
module pau_cell #(
  parameter int FRAC_BITS = pau_pkg::DEF_FRAC_BITS,
  parameter int IDX       = 0
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            adv,
  input  pau_pkg::ctl_t                                   ctl_in,
  input  logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] x_in,
  input  logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] y_in,
  input  logic signed [pau_pkg::Z_W-1:0]                  z_in,
  input  logic [FRAC_BITS+1:0]                            rem_in,
  input  logic [FRAC_BITS:0]                              q_in,
  input  logic [FRAC_BITS:0]                              b_in,
  input  logic [FRAC_BITS:0]                              res_in,
  output pau_pkg::ctl_t                                   ctl_out,
  output logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] x_out,
  output logic signed [FRAC_BITS+pau_pkg::ANG_BITS+pau_pkg::XY_GUARD:0] y_out,
  output logic signed [pau_pkg::Z_W-1:0]                  z_out,
  output logic [FRAC_BITS+1:0]                            rem_out,
  output logic [FRAC_BITS:0]                              q_out,
  output logic [FRAC_BITS:0]                              b_out,
  output logic [FRAC_BITS:0]                              res_out
);
  import pau_pkg::*;

  localparam int PIX_W = FRAC_BITS + 1;
  localparam int REM_W = FRAC_BITS + 2;
  localparam int XY_W  = FRAC_BITS + 1 + ANG_BITS + XY_GUARD;
  localparam logic signed [Z_W-1:0] ATAN_STEP = atan_q30(IDX);

  logic signed [XY_W-1:0] x_sh, y_sh, x_nx, y_nx;
  logic signed [Z_W-1:0]  z_nx;
  logic                   y_pos;
  logic [REM_W-1:0]       rem_nx;
  logic [PIX_W-1:0]       q_nx;

  // Rotate towards the x axis; arithmetic shift floors negative values
  assign x_sh  = x_in >>> IDX;
  assign y_sh  = y_in >>> IDX;
  assign y_pos = !y_in[XY_W-1] && (y_in != '0);

  always_comb begin
    if (y_pos) begin
      x_nx = x_in + y_sh;
      y_nx = y_in - x_sh;
      z_nx = z_in + ATAN_STEP;
    end else begin
      x_nx = x_in - y_sh;
      y_nx = y_in + x_sh;
      z_nx = z_in - ATAN_STEP;
    end
  end

  // One quotient bit per cell while bits remain, else pass through
  generate
    if (IDX <= FRAC_BITS) begin : g_div
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] b_ext;
      logic             ge;
      assign trial  = (IDX == 0) ? rem_in : {rem_in[REM_W-2:0], 1'b0};
      assign b_ext  = {1'b0, b_in};
      assign ge     = (trial >= b_ext);
      assign rem_nx = ge ? (trial - b_ext) : trial;
      assign q_nx   = {q_in[PIX_W-2:0], ge};
    end else begin : g_pass
      assign rem_nx = rem_in;
      assign q_nx   = q_in;
    end
  endgenerate

  // Hold control; clear on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
  end

  // Advance the payload
  always_ff @(posedge clk) begin
    if (adv) begin
      x_out   <= x_nx;
      y_out   <= y_nx;
      z_out   <= z_nx;
      rem_out <= rem_nx;
      q_out   <= q_nx;
      b_out   <= b_in;
      res_out <= res_in;
    end
  end

  // Vectoring keeps x positive for every live angle beat
  a_x_positive: assert property (@(posedge clk) disable iff (rst)
    ctl_out.valid && !ctl_out.fixed && !ctl_out.is_div |-> !x_out[XY_W-1])
    else $error("pau_cell: x went negative on an angle beat");

endmodule

FILE: hdl/pau_back.sv
// ---------------------------------------------------------------------------
// pau_back : result stage of the pixel arithmetic unit
// Rounds the accumulated angle, caps the quotient and selects the result
// into the output register.
// ---------------------------------------------------------------------------
module pau_back #(
  parameter int FRAC_BITS = pau_pkg::DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  pau_pkg::ctl_t                  ctl_in,
  input  logic signed [pau_pkg::Z_W-1:0] z_in,
  input  logic [FRAC_BITS:0]             q_in,
  input  logic [FRAC_BITS:0]             res_in,
  output logic                           out_valid,
  output logic [FRAC_BITS:0]             pixel_out
);
  import pau_pkg::*;

  localparam int PIX_W = FRAC_BITS + 1;
  localparam int RAW_W = FRAC_BITS + 2;
  localparam int SH    = ANG_BITS - FRAC_BITS;
  localparam logic [PIX_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [Z_W-1:0]   RND = Z_W'(1) << (SH - 1);

  logic [Z_W-1:0]   z_pos;
  logic [Z_W-1:0]   z_rnd;
  logic [RAW_W-1:0] ang_raw;
  logic [PIX_W-1:0] ang_pix, div_pix, sel;

  // Drop negative angles, round half up, cap at 1.0
  assign z_pos   = z_in[Z_W-1] ? '0 : z_in;
  assign z_rnd   = z_pos + RND;
  assign ang_raw = z_rnd[ANG_BITS+1:SH];
  assign ang_pix = (ang_raw > {1'b0, ONE}) ? ONE : ang_raw[PIX_W-1:0];

  // Cap the quotient at 1.0
  assign div_pix = (q_in > ONE) ? ONE : q_in;

  always_comb begin
    if (ctl_in.fixed) begin
      sel = res_in;
    end else if (ctl_in.is_div) begin
      sel = div_pix;
    end else begin
      sel = ang_pix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out <= sel;
    end
  end

endmodule

FILE: bench/pixel_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_arithmetic_unit_test : self-checking bench for the pixel ALU
// Feeds pixel pairs through the valid/ready input, runs every operation plus
// the unused opcodes, and checks each result pixel in order against a local
// fixed-point model (CORDIC vectoring for the angle). Both sides idle at
// random; one long output stall fills the pipeline and backs up the input.
// ---------------------------------------------------------------------------
module pixel_arithmetic_unit_test;
  import pau_pkg::*;

  localparam int FRAC_BITS = DEF_FRAC_BITS;
  localparam int PIX_W     = FRAC_BITS + 1;
  localparam int PIX_ONE   = 1 << FRAC_BITS;
  localparam int PIX_MAX   = (1 << PIX_W) - 1;
  localparam int ANGLE_Q   = 30;
  localparam int ROTATIONS = 30;

  // Opcodes past ATAN2 have no operation and give zero
  localparam logic [3:0] OP_SPARE_FIRST = 4'd11;
  localparam logic [3:0] OP_SPARE_LAST  = 4'd15;

  localparam int IDLE_PCT    = 31;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE      = 40;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
  } pixel_pair_t;

  typedef struct {
    logic [3:0]       op;
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] pix;
  } result_pixel_t;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_write = 1'b0;
  logic [3:0]       cfg_data  = 4'd0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] pixel_a   = '0;
  logic [PIX_W-1:0] pixel_b   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] pixel_out;

  pixel_pair_t   pixel_pairs_to_send[$];
  result_pixel_t expected_pixels[$];
  logic [3:0]    op_now    = OP_ADD;
  int            mismatches = 0;
  bit            steady    = 1'b0;
  bit            hold_arm  = 1'b0;
  bit            hold_done = 1'b0;
  int            hold_left = 0;

  // atan(2**-i) in Q30, truncated; later steps follow 2**(30-i) - 1
  longint atan_step [0:11] = '{843314856, 497837829, 263043836, 133525158,
                               67021686, 33543515, 16775850, 8388437,
                               4194282, 2097149, 1048575, 524287};

  int corner_pixels [0:5] = '{0, 1, PIX_ONE - 1, PIX_ONE, PIX_ONE + 1, PIX_MAX};

  pixel_arithmetic_unit #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pixel_a   (pixel_a),
    .pixel_b   (pixel_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected result pixel for one pair under the given operation
  function automatic logic [PIX_W-1:0] predict_pixel(logic [3:0] op,
                                                     logic [PIX_W-1:0] a,
                                                     logic [PIX_W-1:0] b);
    longint r;
    longint x;
    longint y;
    longint z;
    longint nx;
    longint step;
    bit     ta;
    bit     tb;
    ta = (a == PIX_ONE);
    tb = (b == PIX_ONE);
    r  = 0;
    case (op)
      OP_ADD:  r = longint'(a) + b;
      OP_SUB:  r = (a > b) ? longint'(a) - b : 0;
      OP_MUL:  r = (longint'(a) * b) >> FRAC_BITS;
      OP_DIV:  r = (b == 0) ? 0 : (longint'(a) << FRAC_BITS) / b;
      OP_MIN:  r = (a < b) ? longint'(a) : longint'(b);
      OP_MAX:  r = (a > b) ? longint'(a) : longint'(b);
      OP_AND:  r = (ta && tb) ? PIX_ONE : 0;
      OP_OR:   r = (ta || tb) ? PIX_ONE : 0;
      OP_XOR:  r = (ta != tb) ? PIX_ONE : 0;
      OP_NOT:  r = ta ? 0 : PIX_ONE;
      OP_ATAN2: begin
        if (a == 0) begin
          r = 0;
        end else if (b == 0) begin
          r = PIX_ONE;
        end else begin
          // rotate the vector onto the x axis, summing the angle in Q30
          x = longint'(b) <<< ANGLE_Q;
          y = longint'(a) <<< ANGLE_Q;
          z = 0;
          for (int i = 0; i < ROTATIONS; i++) begin
            step = (i < 12) ? atan_step[i] : (longint'(1) <<< (ANGLE_Q - i)) - 1;
            if (y > 0) begin
              nx = x + (y >>> i);
              y  = y - (x >>> i);
              z  = z + step;
            end else begin
              nx = x - (y >>> i);
              y  = y + (x >>> i);
              z  = z - step;
            end
            x = nx;
          end
          if (z < 0) z = 0;
          r = (z + (longint'(1) <<< (ANGLE_Q - FRAC_BITS - 1))) >>> (ANGLE_Q - FRAC_BITS);
        end
      end
      default: r = 0;
    endcase
    if (r > PIX_ONE) r = PIX_ONE;
    return r[PIX_W-1:0];
  endfunction

  // Mostly in range, with corners and over-range pixels mixed in
  function automatic int random_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) return corner_pixels[$urandom_range(0, 5)];
    if (pick < 85) return int'($urandom_range(0, PIX_ONE));
    return int'($urandom_range(PIX_ONE + 1, PIX_MAX));
  endfunction

  // Sender: hold the beat until taken, else offer the next pair or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_pairs_to_send.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        pixel_a  <= pixel_pairs_to_send[0].a;
        pixel_b  <= pixel_pairs_to_send[0].b;
        pixel_pairs_to_send.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off when armed, random idling otherwise
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin
    result_pixel_t exp_pix;
    if (!rst) begin
      if (in_valid && in_ready) begin
        exp_pix.op  = op_now;
        exp_pix.a   = pixel_a;
        exp_pix.b   = pixel_b;
        exp_pix.pix = predict_pixel(op_now, pixel_a, pixel_b);
        expected_pixels.push_back(exp_pix);
      end
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result beat: pixel_out %0d", pixel_out);
        end else begin
          exp_pix = expected_pixels.pop_front();
          if (pixel_out !== exp_pix.pix) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("pixel_out wrong: op %0d a %0d b %0d expected %0d got %0d",
                       exp_pix.op, exp_pix.a, exp_pix.b, exp_pix.pix, pixel_out);
          end
        end
      end
    end
  end

  task automatic set_op(logic [3:0] op);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= op;
    op_now    <= op;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_pair(int a, int b);
    pixel_pair_t p;
    p.a = PIX_W'(a);
    p.b = PIX_W'(b);
    pixel_pairs_to_send.push_back(p);
  endtask

  // Wait until every pair is sent and every result is back
  task automatic drain();
    @(negedge clk);
    while (pixel_pairs_to_send.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int count;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every operation, the named corner cases
    set_op(OP_ADD);
    push_pair(PIX_ONE, PIX_ONE);
    push_pair(PIX_MAX, 0);
    drain();
    set_op(OP_SUB);
    push_pair(0, PIX_ONE);
    push_pair(PIX_ONE, 0);
    drain();
    set_op(OP_MUL);
    push_pair(PIX_ONE, PIX_ONE);
    push_pair(PIX_MAX, PIX_MAX);
    drain();
    set_op(OP_DIV);
    push_pair(5, 0);
    push_pair(PIX_ONE, 1);
    push_pair(1, PIX_ONE);
    drain();
    set_op(OP_MIN);
    push_pair(PIX_MAX, 0);
    drain();
    set_op(OP_MAX);
    push_pair(PIX_MAX, 0);
    drain();
    set_op(OP_AND);
    push_pair(PIX_ONE, PIX_ONE);
    push_pair(PIX_ONE, PIX_ONE + 1);
    drain();
    set_op(OP_OR);
    push_pair(0, PIX_ONE);
    drain();
    set_op(OP_XOR);
    push_pair(PIX_ONE, PIX_ONE);
    push_pair(PIX_ONE, 0);
    drain();
    set_op(OP_NOT);
    push_pair(PIX_ONE, 0);
    push_pair(PIX_ONE + 44, PIX_ONE);
    drain();
    set_op(OP_ATAN2);
    push_pair(0, 0);
    push_pair(5, 0);
    push_pair(1, PIX_ONE);
    push_pair(PIX_MAX, PIX_MAX);
    drain();
    set_op(OP_SPARE_LAST);
    push_pair(PIX_ONE, PIX_ONE);
    drain();
    set_op(OP_SPARE_FIRST);
    push_pair(100, 100);
    drain();

    // Random phases: first one backs up under a long output stall,
    // one runs with no idling on either side
    for (int ph = 0; ph < 9; ph++) begin
      set_op((ph == 0) ? OP_ATAN2 : 4'($urandom_range(0, 15)));
      count    = (ph == 0) ? 80 : 46;
      hold_arm = (ph == 0);
      steady   = (ph == 4);
      for (int i = 0; i < count; i++)
        push_pair(random_pixel(), random_pixel());
      drain();
    end
    steady   = 1'b0;
    hold_arm = 1'b0;

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
